>>> src/rkc_pkg.sv
// Shared types and constants for the 3x3 RGB convolution block.
package rkc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF        = 1024;
  localparam int WEIGHT_FRAC_BITS_DEF = 8;

  // Register field widths
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int WROW_W       = 48;
  localparam int WEIGHT_W     = 16;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_ADDR_W   = 6;
  localparam int CFG_IDX_W    = 3;

  // Register reset values
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = 16'd768;
  localparam logic [WROW_W-1:0]       WTOP_RST   = 48'h0000_0000_0000;
  localparam logic [WROW_W-1:0]       WMID_RST   = 48'h0000_0100_0000;
  localparam logic [WROW_W-1:0]       WBOT_RST   = 48'h0000_0000_0000;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_WEIGHTS_TOP  = 3'd2,
    REG_WEIGHTS_MID  = 3'd3,
    REG_WEIGHTS_BOT  = 3'd4
  } reg_idx_t;

  // Output queue depth
  localparam int FIFO_DEPTH = 8;

  typedef logic [2:0][WROW_W-1:0] weights_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Line store entry: pixel one row up on top, two rows up below
  typedef struct packed {
    pixel_t up1;
    pixel_t up2;
  } line_entry_t;

  typedef pixel_t [2:0][2:0] window_t;

  // Tag that rides along with a window into the arithmetic pipeline
  typedef struct packed {
    logic valid;
    logic frame_end;
  } win_ctl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;
  } result_t;

endpackage

>>> src/rkc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module rkc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/rkc_line_window.sv
// Raster counters, line store read-modify-write and the 3x3 sliding window.
module rkc_line_window
  import rkc_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  pixel_t                  pixel,
  input  logic [WIDTH_REG_W-1:0]  image_width,
  input  logic [HEIGHT_REG_W-1:0] image_height,
  output logic                    emit,
  output window_t                 window,
  output win_ctl_t                win_ctl
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int DIM_W = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;

  logic [COL_W-1:0]        column_count;
  logic [HEIGHT_REG_W-1:0] row_count;
  logic [DIM_W-1:0]        width_x;
  logic [DIM_W-1:0]        width_eff;
  logic [HEIGHT_REG_W-1:0] height_eff;
  logic                    col_last;
  logic                    row_last;

  // Stage 1 registers: pixel waiting for its line store read
  logic             v1;
  logic             emit1;
  logic             fend1;
  pixel_t           cur1;
  logic [COL_W-1:0] addr1;

  line_entry_t rd_entry;
  line_entry_t wr_entry;

  // Clamp the geometry
  always_comb begin
    width_x = DIM_W'(image_width);
    if (width_x < DIM_W'(3)) begin
      width_eff = DIM_W'(3);
    end else if (width_x > DIM_W'(MAX_WIDTH)) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = width_x;
    end
    if (image_height < HEIGHT_REG_W'(3)) begin
      height_eff = HEIGHT_REG_W'(3);
    end else begin
      height_eff = image_height;
    end
    col_last = DIM_W'(column_count) >= (width_eff - DIM_W'(1));
    row_last = row_count >= (height_eff - HEIGHT_REG_W'(1));
    emit     = (row_count >= HEIGHT_REG_W'(2)) && (column_count >= COL_W'(2));
  end

  // Advance the raster position on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_last) begin
        column_count <= '0;
        row_count    <= row_last ? '0 : row_count + HEIGHT_REG_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // Hold the pixel while its line store entry is read
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur1  <= pixel;
      addr1 <= column_count;
      emit1 <= emit;
      fend1 <= emit && row_last && col_last;
    end
  end

  // Columns repeat only every three or more beats, so a read never meets
  // the pending write of the same entry
  assign wr_entry = '{up1: cur1, up2: rd_entry.up1};

  rkc_ram #(
    .WIDTH ($bits(line_entry_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (v1),
    .wr_addr (addr1),
    .wr_data (wr_entry),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_data (rd_entry)
  );

  // Shift the window one column left and load the new right column
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (v1) begin
      for (int r = 0; r < 3; r++) begin
        window[r][0] <= window[r][1];
        window[r][1] <= window[r][2];
      end
      window[0][2] <= rd_entry.up2;
      window[1][2] <= rd_entry.up1;
      window[2][2] <= cur1;
    end
  end

  // Tag the window that completes an interior neighborhood
  always_ff @(posedge clk) begin
    if (rst) begin
      win_ctl <= '0;
    end else begin
      win_ctl.valid     <= v1 && emit1;
      win_ctl.frame_end <= fend1;
    end
  end

endmodule

>>> src/rkc_mac.sv
// Weighted 3x3 sum per channel: multiply, row sums, final sum and saturate.
module rkc_mac
  import rkc_pkg::*;
#(
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  window_t  window,
  input  win_ctl_t win_ctl,
  input  weights_t weights,
  output logic     res_valid,
  output result_t  result
);

  localparam int PROD_W = WEIGHT_W + 9;
  localparam int ROW_W  = PROD_W + 2;
  localparam int SUM_W  = ROW_W + 2;

  // Channel order: 0 red, 1 green, 2 blue
  logic signed [PROD_W-1:0] prod    [3][3][3];
  logic signed [ROW_W-1:0]  row_sum [3][3];
  logic signed [SUM_W-1:0]  total   [3];
  logic signed [SUM_W-1:0]  shifted [3];
  logic [7:0]               sat     [3];
  win_ctl_t                 ctl_a;
  win_ctl_t                 ctl_b;

  function automatic logic [7:0] chan(input pixel_t p, input int ch);
    logic [7:0] v;
    case (ch)
      0:       v = p.red;
      1:       v = p.green;
      default: v = p.blue;
    endcase
    return v;
  endfunction

  // Multiply each pixel channel by its weight
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[ch][r][c] <= $signed({1'b0, chan(window[r][c], ch)}) *
                            $signed(weights[r][WEIGHT_W*c +: WEIGHT_W]);
        end
      end
    end
  end

  // Add the three products of each kernel row
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        row_sum[ch][r] <= ROW_W'(prod[ch][r][0]) + ROW_W'(prod[ch][r][1]) +
                          ROW_W'(prod[ch][r][2]);
      end
    end
  end

  // Drop the fraction and clamp to 0..255
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      total[ch]   = SUM_W'(row_sum[ch][0]) + SUM_W'(row_sum[ch][1]) +
                    SUM_W'(row_sum[ch][2]);
      shifted[ch] = total[ch] >>> WEIGHT_FRAC_BITS;
      if (total[ch] <= 0) begin
        sat[ch] = 8'd0;
      end else if (shifted[ch] > SUM_W'(255)) begin
        sat[ch] = 8'd255;
      end else begin
        sat[ch] = shifted[ch][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    result.red       <= sat[0];
    result.green     <= sat[1];
    result.blue      <= sat[2];
    result.frame_end <= ctl_b.frame_end;
  end

  // Carry the tag alongside the arithmetic
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a     <= '0;
      ctl_b     <= '0;
      res_valid <= 1'b0;
    end else begin
      ctl_a     <= win_ctl;
      ctl_b     <= ctl_a;
      res_valid <= ctl_b.valid;
    end
  end

endmodule

>>> src/rkc_out_fifo.sv
// Output queue that absorbs results while the downstream side stalls.
module rkc_out_fifo
  import rkc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  input  logic    pop,
  output logic    not_empty,
  output result_t head
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  result_t          entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

  // Store incoming results
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

>>> src/rgb_kernel_convolution_3x3.sv
// Top level of the 3x3 RGB convolution: register port, credit control, datapath.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    red_in, green_in, blue_in
//   out      output     out_valid / out_ready  red_out, green_out, blue_out, frame_end
//   cfg      input      APB psel/penable       paddr[5:3] register, pwdata 64 bits
//
// One pixel is accepted per clock while in_ready is high; its line store entry is read
// at the accepting edge. Window shift, multiply, row sums, final sum and clamp, and
// queue write then follow as registered steps in that order; a result is offered
// once it is in the queue.
// Reset clears counters, window and queue; the line store is not cleared.
// An eight-entry output queue with a credit count keeps pixels flowing while
// out_ready is low; in_ready drops only when results in flight fill the queue.
module rgb_kernel_convolution_3x3
  import rkc_pkg::*;
#(
  parameter int MAX_WIDTH        = MAX_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            red_in,
  input  logic [7:0]            green_in,
  input  logic [7:0]            blue_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            red_out,
  output logic [7:0]            green_out,
  output logic [7:0]            blue_out,
  output logic                  frame_end
);

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  weights_t                weights;
  reg_idx_t                reg_idx;
  logic                    cfg_write;

  logic             in_accept;
  logic             out_accept;
  logic             emit;
  logic [CNT_W-1:0] pending;
  pixel_t           pixel;
  window_t          window;
  win_ctl_t         win_ctl;
  logic             res_valid;
  result_t          result;
  result_t          head;

  // Register port
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-CFG_IDX_W]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
      weights[0]   <= WTOP_RST;
      weights[1]   <= WMID_RST;
      weights[2]   <= WBOT_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[HEIGHT_REG_W-1:0];
        REG_WEIGHTS_TOP:  weights[0]   <= pwdata[WROW_W-1:0];
        REG_WEIGHTS_MID:  weights[1]   <= pwdata[WROW_W-1:0];
        REG_WEIGHTS_BOT:  weights[2]   <= pwdata[WROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(image_height);
      REG_WEIGHTS_TOP:  prdata = CFG_DATA_W'(weights[0]);
      REG_WEIGHTS_MID:  prdata = CFG_DATA_W'(weights[1]);
      REG_WEIGHTS_BOT:  prdata = CFG_DATA_W'(weights[2]);
      default:          prdata = '0;
    endcase
  end

  // Credit control: results in flight plus queued never exceed the queue
  assign in_ready   = pending < CNT_W'(FIFO_DEPTH);
  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + CNT_W'(in_accept && emit) - CNT_W'(out_accept);
    end
  end

  assign pixel = '{red: red_in, green: green_in, blue: blue_in};

  rkc_line_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_window (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .pixel        (pixel),
    .image_width  (image_width),
    .image_height (image_height),
    .emit         (emit),
    .window       (window),
    .win_ctl      (win_ctl)
  );

  rkc_mac #(
    .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .window    (window),
    .win_ctl   (win_ctl),
    .weights   (weights),
    .res_valid (res_valid),
    .result    (result)
  );

  rkc_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (result),
    .pop       (out_accept),
    .not_empty (out_valid),
    .head      (head)
  );

  // Drive the result beat
  assign red_out   = head.red;
  assign green_out = head.green;
  assign blue_out  = head.blue;
  assign frame_end = head.frame_end;

endmodule
